// File: rtl/r2p_pkg.sv
package r2p_pkg;

    // Field widths
    localparam int COORD_WIDTH      = 16;
    localparam int FIRST_WIDTH      = COORD_WIDTH + 1;
    localparam int ITERATION_STAGES = 16;

    // Angle datapath: vector scaled to bit 60, accumulator in 2^-23 degree
    localparam int PRE_SHIFT     = 60 - COORD_WIDTH;
    localparam int VEC_W         = 63;
    localparam int FRAC_BITS     = 16;
    localparam int ACC_W         = (FRAC_BITS + COORD_WIDTH > 34) ?
                                   (FRAC_BITS + COORD_WIDTH) : 34;

    // Magnitude datapath
    localparam int ROOT_BITS = COORD_WIDTH;
    localparam int SUM_W     = 2 * COORD_WIDTH;
    localparam int TRIAL_W   = SUM_W + 2;

    // Pipeline depths
    localparam int CORDIC_LAT = ITERATION_STAGES + 2;
    localparam int ROOT_LAT   = ROOT_BITS + 4;
    localparam int PIPE_LAT   = (CORDIC_LAT > ROOT_LAT) ? CORDIC_LAT : ROOT_LAT;
    localparam int ANG_PAD    = PIPE_LAT - CORDIC_LAT;
    localparam int MAG_PAD    = PIPE_LAT - ROOT_LAT;

    // Register port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_POLAR_FORMAT = '0;

    // 180 degrees in 2^-23 degree
    localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(1509949440);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
    } operand_t;

    typedef struct packed {
        logic signed [FIRST_WIDTH-1:0] first_value;
        logic signed [COORD_WIDTH-1:0] second_value;
    } result_t;

    // atan(2^-i) in 2^-23 degree
    function automatic logic signed [ACC_W-1:0] atan_step(input logic [4:0] idx);
        logic signed [ACC_W-1:0] val;
        case (idx)
            5'd0:    val = ACC_W'(377487360);
            5'd1:    val = ACC_W'(222843801);
            5'd2:    val = ACC_W'(117744544);
            5'd3:    val = ACC_W'(59768969);
            5'd4:    val = ACC_W'(30000467);
            5'd5:    val = ACC_W'(15014858);
            5'd6:    val = ACC_W'(7509261);
            5'd7:    val = ACC_W'(3754860);
            5'd8:    val = ACC_W'(1877459);
            5'd9:    val = ACC_W'(938733);
            5'd10:   val = ACC_W'(469367);
            5'd11:   val = ACC_W'(234683);
            5'd12:   val = ACC_W'(117342);
            5'd13:   val = ACC_W'(58671);
            5'd14:   val = ACC_W'(29335);
            5'd15:   val = ACC_W'(14668);
            5'd16:   val = ACC_W'(7334);
            5'd17:   val = ACC_W'(3667);
            5'd18:   val = ACC_W'(1833);
            5'd19:   val = ACC_W'(917);
            5'd20:   val = ACC_W'(458);
            5'd21:   val = ACC_W'(229);
            5'd22:   val = ACC_W'(115);
            5'd23:   val = ACC_W'(57);
            5'd24:   val = ACC_W'(29);
            5'd25:   val = ACC_W'(14);
            5'd26:   val = ACC_W'(7);
            5'd27:   val = ACC_W'(4);
            5'd28:   val = ACC_W'(2);
            5'd29:   val = ACC_W'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// File: rtl/r2p_cordic.sv
module r2p_cordic (
    input  logic                                  clk,
    input  r2p_pkg::operand_t                     operand,
    output logic signed [r2p_pkg::COORD_WIDTH-1:0] angle
);
    import r2p_pkg::*;

    logic signed [COORD_WIDTH:0] x_ext;
    logic signed [COORD_WIDTH:0] y_ext;
    logic signed [COORD_WIDTH:0] x_rot;
    logic signed [COORD_WIDTH:0] y_rot;
    logic signed [ACC_W-1:0]     acc_init;
    logic                        is_zero;

    logic signed [VEC_W-1:0] ax_reg   [ITERATION_STAGES+1];
    logic signed [VEC_W-1:0] ay_reg   [ITERATION_STAGES+1];
    logic signed [ACC_W-1:0] acc_reg  [ITERATION_STAGES+1];
    logic                    zero_reg [ITERATION_STAGES+1];

    logic signed [VEC_W-1:0] ax_next  [ITERATION_STAGES];
    logic signed [VEC_W-1:0] ay_next  [ITERATION_STAGES];
    logic signed [ACC_W-1:0] acc_next [ITERATION_STAGES];

    logic signed [ACC_W-1:0]       rounded;
    logic signed [COORD_WIDTH-1:0] angle_next;
    logic signed [COORD_WIDTH-1:0] angle_reg;

    // Fold the left half-plane into the right one
    always_comb
    begin
        x_ext   = {operand.x_coord[COORD_WIDTH-1], operand.x_coord};
        y_ext   = {operand.y_coord[COORD_WIDTH-1], operand.y_coord};
        is_zero = (operand.x_coord == '0) && (operand.y_coord == '0);
        if (operand.x_coord[COORD_WIDTH-1])
        begin
            x_rot    = -x_ext;
            y_rot    = -y_ext;
            acc_init = operand.y_coord[COORD_WIDTH-1] ? -HALF_TURN : HALF_TURN;
        end
        else
        begin
            x_rot    = x_ext;
            y_rot    = y_ext;
            acc_init = '0;
        end
    end

    // One micro-rotation per stage, driving y towards zero
    always_comb
    begin
        for (int i = 0; i < ITERATION_STAGES; i++)
        begin
            if (!ay_reg[i][VEC_W-1])
            begin
                ax_next[i]  = ax_reg[i] + (ay_reg[i] >>> i);
                ay_next[i]  = ay_reg[i] - (ax_reg[i] >>> i);
                acc_next[i] = acc_reg[i] + atan_step(5'(i));
            end
            else
            begin
                ax_next[i]  = ax_reg[i] - (ay_reg[i] >>> i);
                ay_next[i]  = ay_reg[i] + (ax_reg[i] >>> i);
                acc_next[i] = acc_reg[i] - atan_step(5'(i));
            end
        end
    end

    // Round to 1/128 degree, half up; the zero vector gives zero
    always_comb
    begin
        rounded    = acc_reg[ITERATION_STAGES] + ACC_W'(1 << (FRAC_BITS - 1));
        angle_next = zero_reg[ITERATION_STAGES] ? '0 : rounded[FRAC_BITS +: COORD_WIDTH];
    end

    // Advance the pipeline every cycle
    always_ff @(posedge clk)
    begin
        ax_reg[0]   <= VEC_W'(x_rot) <<< PRE_SHIFT;
        ay_reg[0]   <= VEC_W'(y_rot) <<< PRE_SHIFT;
        acc_reg[0]  <= acc_init;
        zero_reg[0] <= is_zero;
        for (int i = 0; i < ITERATION_STAGES; i++)
        begin
            ax_reg[i+1]   <= ax_next[i];
            ay_reg[i+1]   <= ay_next[i];
            acc_reg[i+1]  <= acc_next[i];
            zero_reg[i+1] <= zero_reg[i];
        end
        angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

// File: rtl/r2p_root.sv
module r2p_root (
    input  logic                               clk,
    input  r2p_pkg::operand_t                  operand,
    output logic [r2p_pkg::FIRST_WIDTH-1:0]    magnitude
);
    import r2p_pkg::*;

    logic [COORD_WIDTH-1:0] abs_x_next;
    logic [COORD_WIDTH-1:0] abs_y_next;
    logic [COORD_WIDTH-1:0] abs_x_reg;
    logic [COORD_WIDTH-1:0] abs_y_reg;
    logic [SUM_W-1:0]       sq_x_next;
    logic [SUM_W-1:0]       sq_y_next;
    logic [SUM_W-1:0]       sq_x_reg;
    logic [SUM_W-1:0]       sq_y_reg;

    logic [SUM_W-1:0]     rem_reg   [ROOT_BITS+1];
    logic [ROOT_BITS-1:0] root_reg  [ROOT_BITS+1];
    logic [SUM_W-1:0]     rem_next  [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_next [ROOT_BITS];
    logic [TRIAL_W-1:0]   trial     [ROOT_BITS];

    logic [FIRST_WIDTH-1:0] mag_next;
    logic [FIRST_WIDTH-1:0] mag_reg;

    // Absolute values and squares
    always_comb
    begin
        abs_x_next = operand.x_coord[COORD_WIDTH-1] ?
                     COORD_WIDTH'(-operand.x_coord) : COORD_WIDTH'(operand.x_coord);
        abs_y_next = operand.y_coord[COORD_WIDTH-1] ?
                     COORD_WIDTH'(-operand.y_coord) : COORD_WIDTH'(operand.y_coord);
        sq_x_next  = SUM_W'(abs_x_reg) * SUM_W'(abs_x_reg);
        sq_y_next  = SUM_W'(abs_y_reg) * SUM_W'(abs_y_reg);
    end

    // Restoring square root, one root bit per stage, most significant first
    always_comb
    begin
        for (int k = 0; k < ROOT_BITS; k++)
        begin
            trial[k] = (TRIAL_W'(root_reg[k]) << (ROOT_BITS - k))
                     + (TRIAL_W'(1) << (2 * (ROOT_BITS - 1 - k)));
            if (TRIAL_W'(rem_reg[k]) >= trial[k])
            begin
                rem_next[k]  = rem_reg[k] - SUM_W'(trial[k]);
                root_next[k] = root_reg[k] | (ROOT_BITS'(1) << (ROOT_BITS - 1 - k));
            end
            else
            begin
                rem_next[k]  = rem_reg[k];
                root_next[k] = root_reg[k];
            end
        end
    end

    // Round to nearest: step up when the remainder exceeds the root
    always_comb
    begin
        mag_next = {1'b0, root_reg[ROOT_BITS]}
                 + FIRST_WIDTH'(rem_reg[ROOT_BITS] > SUM_W'(root_reg[ROOT_BITS]));
    end

    // Advance the pipeline every cycle
    always_ff @(posedge clk)
    begin
        abs_x_reg   <= abs_x_next;
        abs_y_reg   <= abs_y_next;
        sq_x_reg    <= sq_x_next;
        sq_y_reg    <= sq_y_next;
        rem_reg[0]  <= sq_x_reg + sq_y_reg;
        root_reg[0] <= '0;
        for (int k = 0; k < ROOT_BITS; k++)
        begin
            rem_reg[k+1]  <= rem_next[k];
            root_reg[k+1] <= root_next[k];
        end
        mag_reg <= mag_next;
    end

    assign magnitude = mag_reg;

endmodule

// File: rtl/rect_to_polar_converter.sv
// Rectangular to polar converter.
// Input transaction: operand (x_coord, y_coord) is taken on a rising edge
// with start high and busy low. busy never rises, so a new vector can be
// taken on every clock: throughput is one transaction per cycle.
// Result transaction: done is high for one cycle with result valid; it is
// raised as the vector leaves the last pipeline stage, and the result is
// taken at the edge that ends the done cycle. The latency is set by the
// longer of the two pipelines: the square-root pipeline (abs, square, sum,
// one stage per root bit, round) and the CORDIC pipeline (fold, one stage
// per micro-rotation, round). Results leave in input order.
// The receiver cannot hold results off; none is needed, as nothing stalls.
// Mode register polar_format at byte address 0 on the APB port: 0 passes
// x and y through, 1 gives magnitude (first_value) and angle in 1/128
// degree (second_value). The mode is sampled with each vector; change it
// only while no transaction is in flight.
// Reset clears the mode to rectangular and drops every vector in flight.
module rect_to_polar_converter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  r2p_pkg::operand_t             operand,
    output logic                          done,
    output r2p_pkg::result_t              result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [r2p_pkg::ADDR_W-1:0]    paddr,
    input  logic [r2p_pkg::DATA_W-1:0]    pwdata,
    output logic [r2p_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import r2p_pkg::*;

    logic                          polar_format_reg;
    logic                          reg_hit;
    logic                          accept;
    logic [PIPE_LAT-1:0]           valid_reg;
    logic                          mode_reg  [PIPE_LAT];
    logic signed [COORD_WIDTH-1:0] x_del_reg [PIPE_LAT];
    logic signed [COORD_WIDTH-1:0] y_del_reg [PIPE_LAT];

    logic signed [COORD_WIDTH-1:0] angle_raw;
    logic signed [COORD_WIDTH-1:0] angle_aligned;
    logic [FIRST_WIDTH-1:0]        mag_raw;
    logic [FIRST_WIDTH-1:0]        mag_aligned;

    // Register port
    assign reg_hit = (paddr[ADDR_W-1:2] == REG_POLAR_FORMAT);
    assign pready  = 1'b1;
    assign prdata  = (psel && reg_hit) ? DATA_W'(polar_format_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polar_format_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            polar_format_reg <= pwdata[0];
        end
    end

    // Never stall: take a transaction on every start
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Track valid transactions through the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[PIPE_LAT-2:0], accept};
        end
    end

    // Carry mode and raw components alongside
    always_ff @(posedge clk)
    begin
        mode_reg[0]  <= polar_format_reg;
        x_del_reg[0] <= operand.x_coord;
        y_del_reg[0] <= operand.y_coord;
        for (int i = 1; i < PIPE_LAT; i++)
        begin
            mode_reg[i]  <= mode_reg[i-1];
            x_del_reg[i] <= x_del_reg[i-1];
            y_del_reg[i] <= y_del_reg[i-1];
        end
    end

    r2p_cordic u_cordic (
        .clk     (clk),
        .operand (operand),
        .angle   (angle_raw)
    );

    r2p_root u_root (
        .clk       (clk),
        .operand   (operand),
        .magnitude (mag_raw)
    );

    // Align the shorter pipeline to the longer one
    if (ANG_PAD > 0)
    begin : g_ang_pad
        logic signed [COORD_WIDTH-1:0] pad_reg [ANG_PAD];
        always_ff @(posedge clk)
        begin
            pad_reg[0] <= angle_raw;
            for (int i = 1; i < ANG_PAD; i++)
            begin
                pad_reg[i] <= pad_reg[i-1];
            end
        end
        assign angle_aligned = pad_reg[ANG_PAD-1];
    end
    else
    begin : g_ang_direct
        assign angle_aligned = angle_raw;
    end

    if (MAG_PAD > 0)
    begin : g_mag_pad
        logic [FIRST_WIDTH-1:0] pad_reg [MAG_PAD];
        always_ff @(posedge clk)
        begin
            pad_reg[0] <= mag_raw;
            for (int i = 1; i < MAG_PAD; i++)
            begin
                pad_reg[i] <= pad_reg[i-1];
            end
        end
        assign mag_aligned = pad_reg[MAG_PAD-1];
    end
    else
    begin : g_mag_direct
        assign mag_aligned = mag_raw;
    end

    // Select the output format
    assign done = valid_reg[PIPE_LAT-1];

    always_comb
    begin
        if (mode_reg[PIPE_LAT-1])
        begin
            result.first_value  = $signed(mag_aligned);
            result.second_value = angle_aligned;
        end
        else
        begin
            result.first_value  = FIRST_WIDTH'(x_del_reg[PIPE_LAT-1]);
            result.second_value = y_del_reg[PIPE_LAT-1];
        end
    end

endmodule

// File: rtl/r2p_checker.sv
module r2p_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic pready
);
    import r2p_pkg::*;

    // Hold busy low: the pipeline never stalls
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Drop no transaction: every accepted vector returns after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT done)
        else $error("result missing after accepted transaction");

    // Invent no transaction: every result traces back to an accepted vector
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without matching input transaction");

    // Hold pready high: register accesses never wait
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind rect_to_polar_converter r2p_checker u_r2p_checker (.*);
